>>> rtl/led_matrix_frame_serializer_macros.svh
// assertion helpers for the design file that checks itself
`ifndef LED_MATRIX_FRAME_SERIALIZER_MACROS_SVH
`define LED_MATRIX_FRAME_SERIALIZER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define LMFS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define LMFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lmfs_pkg.sv
package lmfs_pkg;

    localparam int MODULES   = 4;
    localparam int WIDTH_PIX = MODULES * 8;
    localparam int STORE_LEN = MODULES * 8;
    localparam int ADDR_W    = $clog2(STORE_LEN);
    localparam int MCNT_W    = (MODULES > 1) ? $clog2(MODULES) : 1;
    localparam int PADDR_W   = 4;

    localparam logic [3:0] REG_INTENSITY = 4'hA;
    localparam logic [3:0] LEVEL_MAX     = 4'hF;

    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_FLUSH = 2'd2,
        KIND_INTEN = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CFG_MODULE_ZERO_RIGHTMOST = 2'd0,
        CFG_BIT_ZERO_RIGHTMOST    = 2'd1,
        CFG_ROW_ZERO_TOP          = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] x;
        logic [2:0] y;
        logic [7:0] value;
    } item_t;

    typedef struct packed {
        logic [3:0] reg_address;
        logic [7:0] reg_data;
        logic       latch;
        logic       last;
    } result_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              clear;
    } store_req_t;

endpackage

>>> rtl/lmfs_store.sv
module lmfs_store (
    input  logic                clk,
    input  logic                rst_n,
    input  lmfs_pkg::store_req_t req,
    output logic [7:0]          rdata
);

    logic [7:0]                     mem_reg [lmfs_pkg::STORE_LEN];
    logic [lmfs_pkg::STORE_LEN-1:0] valid_reg;
    logic [lmfs_pkg::STORE_LEN-1:0] valid_next;
    logic [7:0]                     rdata_reg;
    logic                           rhit_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem_reg[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem_reg[req.rd_addr];
        end
    end

    // an entry never written since reset or clear reads as zero
    always_comb
    begin
        valid_next = valid_reg;
        if (req.clear)
        begin
            valid_next = '0;
        end
        else if (req.wr_en)
        begin
            valid_next[req.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rhit_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (req.rd_en)
            begin
                rhit_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rdata = rhit_reg ? rdata_reg : 8'h00;

endmodule

>>> rtl/led_matrix_frame_serializer.sv
// channel  | ports                         | handshake
// item     | start, busy, item             | taken when start and not busy
// result   | result_valid, result          | one word per cycle, no stall
// config   | psel penable pwrite paddr ... | written at access cycle, pready high
//
// set pixel: busy in ST_PIX_RD (store read), then ST_PIX_WR (write); out of range: none
// clear frame: never busy, the store's valid bits drop at once
// flush: busy until the last word is out, one word a cycle off the store read port
// intensity: busy until the last word is out, one word a cycle
// reset leaves the frame store reading as all zeros; results cannot be held off
`include "led_matrix_frame_serializer_macros.svh"

module led_matrix_frame_serializer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  lmfs_pkg::item_t               item,
    output logic                          result_valid,
    output lmfs_pkg::result_t             result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lmfs_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_PIX_RD = 5'b00010,
        ST_PIX_WR = 5'b00100,
        ST_FLUSH  = 5'b01000,
        ST_INTEN  = 5'b10000
    } state_t;

    localparam logic [lmfs_pkg::MCNT_W-1:0] MOD_LAST =
        lmfs_pkg::MCNT_W'(lmfs_pkg::MODULES - 1);
    localparam logic [5:0] X_MAX = 6'(lmfs_pkg::WIDTH_PIX - 1);

    state_t                        state_reg, state_next;
    logic                          mzr_reg, mzr_next;
    logic                          bzr_reg, bzr_next;
    logic                          rzt_reg, rzt_next;
    logic [lmfs_pkg::MCNT_W-1:0]   mod_reg, mod_next;
    logic [2:0]                    row_reg, row_next;
    logic                          pend_reg, pend_next;
    logic [lmfs_pkg::ADDR_W-1:0]   idx_reg, idx_next;
    logic [7:0]                    mask_reg, mask_next;
    logic [3:0]                    level_reg, level_next;
    logic [3:0]                    paddr_reg, paddr_next;
    logic                          platch_reg, platch_next;
    logic                          plast_reg, plast_next;
    logic                          pmem_reg, pmem_next;

    lmfs_pkg::store_req_t          req;
    logic [7:0]                    store_rdata;
    logic                          accept;
    logic                          cfg_wr;
    logic [1:0]                    cfg_idx;
    logic [5:0]                    x_flip;
    logic [2:0]                    pix_row;
    logic [5:0]                    pix_idx;
    logic                          in_range;

    lmfs_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rdata (store_rdata)
    );

    assign busy    = (state_reg != ST_IDLE) || pend_reg;
    assign accept  = start && !busy;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[lmfs_pkg::PADDR_W-1:2];
    assign pready  = 1'b1;

    // module count from the right only flips the module, local column stays x mod 8
    assign x_flip   = X_MAX - item.x;
    assign pix_row  = rzt_reg ? item.y : ~item.y;
    assign pix_idx  = mzr_reg ? {x_flip[5:3], pix_row} : {item.x[5:3], pix_row};
    assign in_range = {1'b0, item.x} < 7'(lmfs_pkg::WIDTH_PIX);

    always_comb
    begin
        mzr_next = mzr_reg;
        bzr_next = bzr_reg;
        rzt_next = rzt_reg;
        if (cfg_wr)
        begin
            unique case (cfg_idx)
                lmfs_pkg::CFG_MODULE_ZERO_RIGHTMOST: mzr_next = pwdata[0];
                lmfs_pkg::CFG_BIT_ZERO_RIGHTMOST:    bzr_next = pwdata[0];
                lmfs_pkg::CFG_ROW_ZERO_TOP:          rzt_next = pwdata[0];
                default:                             ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            lmfs_pkg::CFG_MODULE_ZERO_RIGHTMOST: prdata = {31'd0, mzr_reg};
            lmfs_pkg::CFG_BIT_ZERO_RIGHTMOST:    prdata = {31'd0, bzr_reg};
            lmfs_pkg::CFG_ROW_ZERO_TOP:          prdata = {31'd0, rzt_reg};
            default:                             prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        mod_next    = mod_reg;
        row_next    = row_reg;
        pend_next   = 1'b0;
        idx_next    = idx_reg;
        mask_next   = mask_reg;
        level_next  = level_reg;
        paddr_next  = paddr_reg;
        platch_next = platch_reg;
        plast_next  = plast_reg;
        pmem_next   = pmem_reg;
        req         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (item.kind)
                        lmfs_pkg::KIND_PIXEL:
                        begin
                            if (in_range)
                            begin
                                idx_next   = lmfs_pkg::ADDR_W'(pix_idx);
                                mask_next  = bzr_reg ? (8'h01 << item.x[2:0])
                                                     : (8'h80 >> item.x[2:0]);
                                state_next = ST_PIX_RD;
                            end
                        end
                        lmfs_pkg::KIND_CLEAR:
                        begin
                            req.clear = 1'b1;
                        end
                        lmfs_pkg::KIND_FLUSH:
                        begin
                            row_next   = 3'd0;
                            mod_next   = MOD_LAST;
                            state_next = ST_FLUSH;
                        end
                        default:
                        begin
                            level_next = (item.value > {4'd0, lmfs_pkg::LEVEL_MAX})
                                         ? lmfs_pkg::LEVEL_MAX : item.value[3:0];
                            mod_next   = MOD_LAST;
                            state_next = ST_INTEN;
                        end
                    endcase
                end
            end
            ST_PIX_RD:
            begin
                req.rd_en   = 1'b1;
                req.rd_addr = idx_reg;
                state_next  = ST_PIX_WR;
            end
            ST_PIX_WR:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = idx_reg;
                req.wr_data = store_rdata | mask_reg;
                state_next  = ST_IDLE;
            end
            ST_FLUSH:
            begin
                // read now, the word goes out next cycle with the read data
                req.rd_en   = 1'b1;
                req.rd_addr = lmfs_pkg::ADDR_W'({mod_reg, row_reg});
                pend_next   = 1'b1;
                pmem_next   = 1'b1;
                paddr_next  = {1'b0, row_reg} + 4'd1;
                platch_next = (mod_reg == '0);
                plast_next  = (mod_reg == '0) && (row_reg == 3'd7);
                if (mod_reg == '0)
                begin
                    mod_next = MOD_LAST;
                    row_next = row_reg + 3'd1;
                    if (row_reg == 3'd7)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    mod_next = mod_reg - 1'b1;
                end
            end
            ST_INTEN:
            begin
                pend_next   = 1'b1;
                pmem_next   = 1'b0;
                paddr_next  = lmfs_pkg::REG_INTENSITY;
                platch_next = (mod_reg == '0);
                plast_next  = (mod_reg == '0);
                if (mod_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    mod_next = mod_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mzr_reg   <= 1'b1;
            bzr_reg   <= 1'b0;
            rzt_reg   <= 1'b1;
            mod_reg   <= '0;
            row_reg   <= 3'd0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mzr_reg   <= mzr_next;
            bzr_reg   <= bzr_next;
            rzt_reg   <= rzt_next;
            mod_reg   <= mod_next;
            row_reg   <= row_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        mask_reg   <= mask_next;
        level_reg  <= level_next;
        paddr_reg  <= paddr_next;
        platch_reg <= platch_next;
        plast_reg  <= plast_next;
        pmem_reg   <= pmem_next;
    end

    assign result_valid       = pend_reg;
    assign result.reg_address = paddr_reg;
    assign result.reg_data    = pmem_reg ? store_rdata : {4'd0, level_reg};
    assign result.latch       = platch_reg;
    assign result.last        = plast_reg;

    `LMFS_ASSERT_IMP(a_word_while_busy, result_valid, busy, "word sent while not busy")
    `LMFS_ASSERT_NEXT(a_idle_after_last, result_valid && result.last, !busy,
        "still busy after final word")
    `LMFS_ASSERT_NEXT(a_flush_goes_busy,
        accept && (item.kind == lmfs_pkg::KIND_FLUSH), busy, "flush did not start")
    `LMFS_ASSERT_IMP(a_last_has_latch, result_valid && result.last, result.latch,
        "final word without latch")

endmodule

>>> tb/sv/led_matrix_frame_serializer_test.sv
module led_matrix_frame_serializer_test;
    import lmfs_pkg::*;

    localparam int IDLE_LIMIT       = 3000;
    localparam int SETTLE_CYCLES    = 40;
    localparam int PIXEL_CYCLES     = 4;
    localparam int GROUPS           = 8;
    localparam int GROUP_ITEMS      = 22;
    localparam int UNUSED_REG_INDEX = 3;

    logic                 clk     = 1'b0;
    logic                 rst_n   = 1'b0;
    logic                 start   = 1'b0;
    logic                 busy;
    item_t                item    = '0;
    logic                 result_valid;
    result_t              result;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [PADDR_W-1:0]   paddr   = '0;
    logic [31:0]          pwdata  = '0;
    logic [31:0]          prdata;
    logic                 pready;

    item_t   pending_items[$];
    result_t expected_words[$];

    // local copy of the frame store and the orientation settings
    logic [7:0] frame_model [STORE_LEN];
    logic       mod_from_right = 1'b1;
    logic       bit_from_right = 1'b0;
    logic       row_from_top   = 1'b1;

    int idle_pct    = 0;
    int error_count = 0;
    int idle_cycles = 0;

    led_matrix_frame_serializer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic item_t make_item(kind_t k, int x_pos, int y_pos, int level);
        item_t it;
        it.kind  = k;
        it.x     = x_pos[5:0];
        it.y     = y_pos[2:0];
        it.value = level[7:0];
        return it;
    endfunction

    function automatic void push_word(logic [3:0] addr, logic [7:0] data, logic l, logic f);
        result_t w;
        w.reg_address = addr;
        w.reg_data    = data;
        w.latch       = l;
        w.last        = f;
        expected_words.push_back(w);
    endfunction

    function automatic void predict_words(item_t it);
        int         mod_idx;
        int         bit_idx;
        int         row_idx;
        logic [3:0] level;
        case (it.kind)
            KIND_PIXEL:
            begin
                if (it.x < WIDTH_PIX)
                begin
                    mod_idx = mod_from_right ? (WIDTH_PIX - 1 - it.x) / 8 : it.x / 8;
                    // local column stays x mod 8 even when modules count from the right
                    bit_idx = bit_from_right ? it.x % 8 : 7 - it.x % 8;
                    row_idx = row_from_top ? it.y : 7 - it.y;
                    frame_model[mod_idx * 8 + row_idx][bit_idx] = 1'b1;
                end
            end
            KIND_CLEAR:
            begin
                foreach (frame_model[i])
                    frame_model[i] = '0;
            end
            KIND_FLUSH:
            begin
                for (int r = 0; r < 8; r++)
                    for (int m = MODULES - 1; m >= 0; m--)
                        push_word(4'(r + 1), frame_model[m * 8 + r], m == 0,
                                  m == 0 && r == 7);
            end
            KIND_INTEN:
            begin
                level = (it.value > LEVEL_MAX) ? LEVEL_MAX : it.value[3:0];
                for (int m = 0; m < MODULES; m++)
                    push_word(REG_INTENSITY, {4'b0, level}, m == MODULES - 1,
                              m == MODULES - 1);
            end
            default: ;
        endcase
    endfunction

    // driver: one item offered at a time, held until taken
    always @(posedge clk)
    begin
        logic offering;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            offering = start;
            if (start && !busy)
            begin
                predict_words(item);
                offering = 1'b0;
            end
            if (!offering)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    start <= 1'b1;
                    item  <= pending_items.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected word: %p", result);
                error_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (result.reg_address !== want.reg_address)
                begin
                    $error("reg_address: expected %0d, got %0d", want.reg_address,
                           result.reg_address);
                    error_count++;
                end
                if (result.reg_data !== want.reg_data)
                begin
                    $error("reg_data: expected 0x%02h, got 0x%02h", want.reg_data,
                           result.reg_data);
                    error_count++;
                end
                if (result.latch !== want.latch)
                begin
                    $error("latch: expected %0b, got %0b", want.latch, result.latch);
                    error_count++;
                end
                if (result.last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, result.last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (psel && penable))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // checked on the falling edge so the driver's decision for this cycle has settled
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || start || busy || expected_words.size() != 0);
        // a set pixel leaves no word behind, give its store write time to finish
        repeat (PIXEL_CYCLES) @(posedge clk);
    endtask

    task automatic write_setting(int index, logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(index * 4);
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            CFG_MODULE_ZERO_RIGHTMOST: mod_from_right = data[0];
            CFG_BIT_ZERO_RIGHTMOST:    bit_from_right = data[0];
            CFG_ROW_ZERO_TOP:          row_from_top   = data[0];
            default: ;
        endcase
    endtask

    initial
    begin
        int   made;
        int   burst;
        int   x_pos;
        item_t noise;
        foreach (frame_model[i])
            frame_model[i] = '0;

        // reset state, module and range edges, unused fields set, clamp edges
        pending_items.push_back(make_item(KIND_FLUSH, 0, 0, 0));
        pending_items.push_back(make_item(KIND_PIXEL, 0, 0, 255));
        pending_items.push_back(make_item(KIND_PIXEL, 31, 7, 0));
        pending_items.push_back(make_item(KIND_PIXEL, 63, 7, 0));
        pending_items.push_back(make_item(KIND_PIXEL, 32, 3, 0));
        pending_items.push_back(make_item(KIND_PIXEL, 7, 4, 0));
        pending_items.push_back(make_item(KIND_PIXEL, 8, 4, 0));
        pending_items.push_back(make_item(KIND_FLUSH, 63, 7, 255));
        pending_items.push_back(make_item(KIND_INTEN, 0, 0, 0));
        pending_items.push_back(make_item(KIND_INTEN, 0, 0, 15));
        pending_items.push_back(make_item(KIND_INTEN, 0, 0, 16));
        pending_items.push_back(make_item(KIND_INTEN, 63, 7, 255));
        pending_items.push_back(make_item(KIND_CLEAR, 63, 7, 255));
        pending_items.push_back(make_item(KIND_FLUSH, 0, 0, 0));
        pending_items.push_back(make_item(KIND_PIXEL, 5, 2, 0));
        pending_items.push_back(make_item(KIND_CLEAR, 0, 0, 0));
        pending_items.push_back(make_item(KIND_FLUSH, 0, 0, 0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        wait_quiet();
        write_setting(UNUSED_REG_INDEX, $urandom());

        for (int g = 0; g < GROUPS; g++)
        begin
            // every orientation combination, upper data bits random
            write_setting(CFG_MODULE_ZERO_RIGHTMOST, ($urandom() & ~32'd1) | g[0]);
            write_setting(CFG_BIT_ZERO_RIGHTMOST, ($urandom() & ~32'd1) | g[1]);
            write_setting(CFG_ROW_ZERO_TOP, ($urandom() & ~32'd1) | g[2]);
            idle_pct = (g < 3) ? 8 : (g < 6) ? 87 : 0;
            made = 0;
            while (made < GROUP_ITEMS)
            begin
                if ($urandom_range(99) < 80)
                begin
                    // draw a frame and push it out
                    if ($urandom_range(99) < 70)
                    begin
                        pending_items.push_back(make_item(KIND_CLEAR, $urandom_range(63),
                            $urandom_range(7), $urandom_range(255)));
                        made++;
                    end
                    burst = $urandom_range(12, 3);
                    repeat (burst)
                    begin
                        x_pos = ($urandom_range(99) < 85) ? $urandom_range(WIDTH_PIX - 1)
                                                          : $urandom_range(63, WIDTH_PIX);
                        pending_items.push_back(make_item(KIND_PIXEL, x_pos,
                            $urandom_range(7), $urandom_range(255)));
                        if (x_pos < WIDTH_PIX)
                            made++;
                    end
                    if ($urandom_range(99) < 30)
                    begin
                        pending_items.push_back(make_item(KIND_INTEN, $urandom_range(63),
                            $urandom_range(7), $urandom_range(255)));
                        made++;
                    end
                    pending_items.push_back(make_item(KIND_FLUSH, $urandom_range(63),
                        $urandom_range(7), $urandom_range(255)));
                    made++;
                end
                else
                begin
                    noise = make_item(kind_t'($urandom_range(3)), $urandom_range(63),
                                      $urandom_range(7), $urandom_range(255));
                    pending_items.push_back(noise);
                    if (noise.kind != KIND_PIXEL || noise.x < WIDTH_PIX)
                        made++;
                end
            end
            wait_quiet();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> led_matrix_frame_serializer.f
+incdir+rtl
rtl/lmfs_pkg.sv
rtl/lmfs_store.sv
rtl/led_matrix_frame_serializer.sv
tb/sv/led_matrix_frame_serializer_test.sv
